>>> rtl/core/ctgae_pkg.sv
package ctgae_pkg;

    // Beat widths on the two stream sides
    localparam int IN_W  = 96;
    localparam int OUT_W = 56;

    // Fixed field widths
    localparam int LEN_FIELD_W = 20;
    localparam int LVL_INT_W   = 16;
    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 17;
    localparam int PULSE_W     = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_DISABLE_UNARM = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_MODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LEN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ENV_LEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENV_LEN   = 3'd4;

    // Toggle states
    typedef enum logic [1:0] {
        TG_IDLE   = 2'd0,
        TG_ARMED  = 2'd1,
        TG_GATING = 2'd2,
        TG_DISARM = 2'd3
    } t_toggle;

    // Envelope stages
    typedef enum logic [1:0] {
        ENV_STOP    = 2'd0,
        ENV_ATTACK  = 2'd1,
        ENV_SUSTAIN = 2'd2,
        ENV_RELEASE = 2'd3
    } t_env_stage;

endpackage

>>> rtl/core/ctgae_div.sv
module ctgae_div #(
    parameter int DW = 24,
    parameter int VW = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);
    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_den;

    logic [VW:0]   w_shift;
    logic [VW:0]   w_diff;
    logic          w_ge;

    // Shift in the next dividend bit and try one subtract
    assign w_shift = {r_rem, r_quo[DW-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_ge    = (w_shift >= {1'b0, r_den});

    // Control: count the quotient bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(DW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: restoring division, one bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[VW-1:0] : w_shift[VW-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> rtl/core/ctgae_vca.sv
module ctgae_vca (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [ctgae_pkg::SAMPLE_W-1:0] i_sample,
    input  logic        [ctgae_pkg::GAIN_W-1:0]   i_gain,
    output logic signed [ctgae_pkg::SAMPLE_W-1:0] o_scaled
);
    import ctgae_pkg::*;

    localparam int PW = SAMPLE_W + GAIN_W + 1;

    logic signed [PW-1:0] r_prod;

    // Multiply one channel by the gain and hold the product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_sample * $signed({1'b0, i_gain});
        end
    end

    // Arithmetic shift by 16 floors toward minus infinity
    assign o_scaled = r_prod[SAMPLE_W+15:16];

endmodule

>>> rtl/core/clocked_toggle_gate_asr_envelope_unit.sv
// Clock-synced toggle gate with an attack/sustain/release envelope and stereo VCA.
// Input stream: one beat per audio sample period carries the clock, arm and reset
// levels, sustain, attack and release lengths and a stereo sample pair.
// Output stream: one beat per input beat with the scaled pair, gate, pending and
// active flags and the current envelope level.
// Configuration: write enable, register index and data; write only while idle.
// Sequence: an input beat that starts an attack or release first waits for the
// bit-serial step divider, which produces one quotient bit a cycle; every beat
// then goes through envelope update, two passes of the shared multiplier and the
// output load.
// Throughput: one item at a time, the next beat taken in the cycle after the output
// load at the earliest; tready is high only while the sequencer waits for a beat.
// Receiver stall: a finished beat sits in the output register and the next input
// beat is still taken; the sequencer waits before its final load until the
// output register frees up.
// Reset (synchronous, active low): idle toggle state, envelope stopped at zero,
// edge detectors cleared and registers at their defaults.
module clocked_toggle_gate_asr_envelope_unit #(
    parameter int LEN_BITS  = 20,
    parameter int FRAC_BITS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // clock_level, arm_level, reset_level, sustain_sum[17:0], attack_len[19:0],
    // release_len[19:0], in_left[15:0], in_right[15:0], left_connected,
    // right_connected, zero fill
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [ctgae_pkg::IN_W-1:0]            i_s_axis_tdata,
    // out_left[15:0], out_right[15:0], gate_out, pending_flag, active_flag,
    // envelope[15:0], zero fill
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [ctgae_pkg::OUT_W-1:0]           o_m_axis_tdata,
    input  logic                                  i_cfg_we,
    input  logic [ctgae_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ctgae_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import ctgae_pkg::*;

    localparam int LW  = (LEN_BITS < LEN_FIELD_W) ? LEN_BITS : LEN_FIELD_W;
    localparam int LVW = LVL_INT_W + FRAC_BITS;
    localparam logic [LVW-1:0] FULL_LEVEL = LVW'(16'hFFFF) << FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_DIV  = 3'd1,
        S_ENV  = 3'd2,
        S_MULL = 3'd3,
        S_MULR = 3'd4,
        S_DONE = 3'd5
    } t_seq;

    // Configuration registers
    logic                   r_disable_unarm;
    logic                   r_trigger_mode;
    logic [PULSE_W-1:0]     r_pulse_len;
    logic [LEN_FIELD_W-1:0] r_min_env_len;
    logic [LEN_FIELD_W-1:0] r_max_env_len;

    // Control state
    t_seq                   r_seq;
    t_toggle                r_toggle;
    t_env_stage             r_stage;
    logic [LVW-1:0]         r_level;
    logic [LVW-1:0]         r_step;
    logic                   r_prev_clock;
    logic                   r_prev_arm;
    logic                   r_prev_reset;
    logic                   r_gate;
    logic                   r_pulse_active;
    logic [PULSE_W-1:0]     r_pulse_cnt;
    logic                   r_pending;
    logic                   r_active;
    logic                   r_ovalid;

    // Item payload held over the sequence
    logic [LVW-1:0]               r_sustain;
    logic signed [SAMPLE_W-1:0]   r_in_left;
    logic signed [SAMPLE_W-1:0]   r_in_right;
    logic                         r_left_conn;
    logic                         r_right_conn;
    logic signed [SAMPLE_W-1:0]   r_left_tmp;

    // Output beat
    logic signed [SAMPLE_W-1:0]   r_o_left;
    logic signed [SAMPLE_W-1:0]   r_o_right;
    logic                         r_o_gate;
    logic                         r_o_pending;
    logic                         r_o_active;
    logic [LVL_INT_W-1:0]         r_o_env;

    // Input fields
    logic                         f_clock;
    logic                         f_arm;
    logic                         f_reset;
    logic signed [17:0]           f_sustain;
    logic [LEN_FIELD_W-1:0]       f_attack;
    logic [LEN_FIELD_W-1:0]       f_release;
    logic signed [SAMPLE_W-1:0]   f_in_left;
    logic signed [SAMPLE_W-1:0]   f_in_right;
    logic                         f_left_conn;
    logic                         f_right_conn;

    assign f_clock      = i_s_axis_tdata[0];
    assign f_arm        = i_s_axis_tdata[1];
    assign f_reset      = i_s_axis_tdata[2];
    assign f_sustain    = i_s_axis_tdata[20:3];
    assign f_attack     = i_s_axis_tdata[40:21];
    assign f_release    = i_s_axis_tdata[60:41];
    assign f_in_left    = i_s_axis_tdata[76:61];
    assign f_in_right   = i_s_axis_tdata[92:77];
    assign f_left_conn  = i_s_axis_tdata[93];
    assign f_right_conn = i_s_axis_tdata[94];

    logic w_accept;
    assign o_s_axis_tready = (r_seq == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Saturate sustain to 0..1.0
    logic [LVL_INT_W-1:0] w_sus16;
    logic [LVW-1:0]       w_sustain;
    always_comb begin
        if (f_sustain[17]) begin
            w_sus16 = '0;
        end else if (f_sustain[16]) begin
            w_sus16 = 16'hFFFF;
        end else begin
            w_sus16 = f_sustain[15:0];
        end
    end
    assign w_sustain = LVW'(w_sus16) << FRAC_BITS;

    // Clamp attack and release lengths
    logic [LW-1:0] w_min_len;
    logic [LW-1:0] w_max_len;
    logic [LW-1:0] w_atk_len;
    logic [LW-1:0] w_rel_len;
    logic [LW-1:0] w_atk_eff;
    logic [LW-1:0] w_rel_eff;
    logic          w_atk_ok;
    logic          w_rel_ok;

    assign w_min_len = r_min_env_len[LW-1:0];
    assign w_max_len = r_max_env_len[LW-1:0];
    assign w_atk_len = f_attack[LW-1:0];
    assign w_rel_len = f_release[LW-1:0];
    assign w_atk_eff = (w_atk_len > w_max_len) ? w_max_len : w_atk_len;
    assign w_rel_eff = (w_rel_len > w_max_len) ? w_max_len : w_rel_len;
    assign w_atk_ok  = !(w_atk_len < w_min_len) && (w_atk_eff != '0);
    assign w_rel_ok  = !(w_rel_len < w_min_len) && (w_rel_eff != '0);

    // Edge detect the control levels
    logic w_clk_edge;
    logic w_arm_edge;
    logic w_rst_edge;
    assign w_clk_edge = f_clock && !r_prev_clock;
    assign w_arm_edge = f_arm && !r_prev_arm;
    assign w_rst_edge = f_reset && !r_prev_reset;

    // Toggle state machine, gate and pulse for the beat being accepted
    t_toggle            n_toggle;
    t_env_stage         n_stage;
    logic [LVW-1:0]     n_level;
    logic               n_gate;
    logic               n_pulse_active;
    logic [PULSE_W-1:0] n_pulse_cnt;
    logic               w_div_go;
    logic [LVW-1:0]     w_div_num;
    logic [LW-1:0]      w_div_den;

    always_comb begin
        n_toggle       = r_toggle;
        n_stage        = r_stage;
        n_level        = r_level;
        n_gate         = r_gate;
        n_pulse_active = r_pulse_active;
        n_pulse_cnt    = r_pulse_cnt;
        w_div_go       = 1'b0;
        w_div_num      = '0;
        w_div_den      = '0;

        // Reset edge: stop the envelope, go idle, drop the gate or fire a pulse if gating in trigger mode
        if (w_rst_edge) begin
            n_gate = 1'b0;
            if (r_trigger_mode && (n_toggle == TG_GATING)) begin
                n_gate         = 1'b1;
                n_pulse_active = 1'b1;
                n_pulse_cnt    = r_pulse_len;
            end
            n_stage  = ENV_STOP;
            n_level  = '0;
            n_toggle = TG_IDLE;
        end

        unique case (n_toggle)
            TG_IDLE: begin
                if (w_arm_edge) begin
                    n_toggle = TG_ARMED;
                end
            end
            TG_ARMED: begin
                if (w_arm_edge && !r_disable_unarm) begin
                    n_gate   = 1'b0;
                    n_toggle = TG_IDLE;
                end else if (w_clk_edge) begin
                    n_gate = 1'b1;
                    if (r_trigger_mode) begin
                        n_pulse_active = 1'b1;
                        n_pulse_cnt    = r_pulse_len;
                    end
                    n_toggle = TG_GATING;
                    if (w_atk_ok) begin
                        n_stage   = ENV_ATTACK;
                        w_div_go  = 1'b1;
                        w_div_num = (FULL_LEVEL > n_level) ? (FULL_LEVEL - n_level) : '0;
                        w_div_den = w_atk_eff;
                    end else begin
                        n_stage = ENV_SUSTAIN;
                    end
                end
            end
            TG_GATING: begin
                if (!r_trigger_mode) begin
                    n_gate = 1'b1;
                end
                if (w_arm_edge) begin
                    n_toggle = TG_DISARM;
                end
            end
            TG_DISARM: begin
                if (w_arm_edge && !r_disable_unarm) begin
                    n_toggle = TG_GATING;
                end else if (w_clk_edge) begin
                    if (!r_trigger_mode) begin
                        n_gate = 1'b0;
                    end else begin
                        n_gate         = 1'b1;
                        n_pulse_active = 1'b1;
                        n_pulse_cnt    = r_pulse_len;
                    end
                    n_toggle = TG_IDLE;
                    if (w_rel_ok) begin
                        n_stage   = ENV_RELEASE;
                        w_div_go  = 1'b1;
                        w_div_num = n_level;
                        w_div_den = w_rel_eff;
                    end else begin
                        n_stage = ENV_STOP;
                    end
                end
            end
        endcase

        // Count down the trigger pulse
        if (r_trigger_mode && n_pulse_active) begin
            if (n_pulse_cnt == '0) begin
                n_pulse_active = 1'b0;
                n_gate         = 1'b0;
            end else begin
                n_pulse_cnt = n_pulse_cnt - PULSE_W'(1);
            end
        end
    end

    // Step divider
    logic           w_div_done;
    logic [LVW-1:0] w_quotient;

    ctgae_div #(
        .DW (LVW),
        .VW (LW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept && w_div_go),
        .i_dividend (w_div_num),
        .i_divisor  (w_div_den),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // Envelope advance by one sample
    logic [LVW:0]   w_sum;
    logic [LVW-1:0] w_env_level;
    t_env_stage     w_env_stage;

    assign w_sum = {1'b0, r_level} + {1'b0, r_step};

    always_comb begin
        w_env_level = r_level;
        w_env_stage = r_stage;
        unique case (r_stage)
            ENV_ATTACK: begin
                if (w_sum >= {1'b0, r_sustain}) begin
                    w_env_level = r_sustain;
                    w_env_stage = ENV_SUSTAIN;
                end else begin
                    w_env_level = w_sum[LVW-1:0];
                end
            end
            ENV_SUSTAIN: begin
                w_env_level = r_sustain;
            end
            ENV_RELEASE: begin
                if (r_step > r_level) begin
                    w_env_level = '0;
                    w_env_stage = ENV_STOP;
                end else begin
                    w_env_level = r_level - r_step;
                end
            end
            ENV_STOP: begin
                w_env_level = '0;
                w_env_stage = ENV_STOP;
            end
        endcase
    end

    // Gain from the envelope, 0..65536
    logic [LVL_INT_W-1:0] w_env16;
    logic [GAIN_W-1:0]    w_gain;
    assign w_env16 = r_level[LVW-1:FRAC_BITS];
    assign w_gain  = {1'b0, w_env16} + GAIN_W'(w_env16[LVL_INT_W-1]);

    // Shared multiplier, left pass then right pass
    logic                       w_vca_en;
    logic signed [SAMPLE_W-1:0] w_vca_sample;
    logic signed [SAMPLE_W-1:0] w_vca_out;

    assign w_vca_en = (r_seq == S_MULL) || (r_seq == S_MULR);

    always_comb begin
        if (r_seq == S_MULL) begin
            w_vca_sample = r_left_conn ? r_in_left : 16'sh7FFF;
        end else begin
            w_vca_sample = r_right_conn ? r_in_right : 16'sh7FFF;
        end
    end

    ctgae_vca u_vca (
        .i_clk    (i_clk),
        .i_en     (w_vca_en),
        .i_sample (w_vca_sample),
        .i_gain   (w_gain),
        .o_scaled (w_vca_out)
    );

    logic w_load_out;
    assign w_load_out = (r_seq == S_DONE) && (!r_ovalid || i_m_axis_tready);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disable_unarm <= 1'b0;
            r_trigger_mode  <= 1'b0;
            r_pulse_len     <= 16'd48;
            r_min_env_len   <= 20'd48;
            r_max_env_len   <= 20'd480000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DISABLE_UNARM: r_disable_unarm <= i_cfg_data[0];
                CFG_TRIGGER_MODE:  r_trigger_mode  <= i_cfg_data[0];
                CFG_PULSE_LEN:     r_pulse_len     <= i_cfg_data[PULSE_W-1:0];
                CFG_MIN_ENV_LEN:   r_min_env_len   <= i_cfg_data;
                CFG_MAX_ENV_LEN:   r_max_env_len   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer, block state and output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq          <= S_IDLE;
            r_toggle       <= TG_IDLE;
            r_stage        <= ENV_STOP;
            r_level        <= '0;
            r_step         <= '0;
            r_prev_clock   <= 1'b0;
            r_prev_arm     <= 1'b0;
            r_prev_reset   <= 1'b0;
            r_gate         <= 1'b0;
            r_pulse_active <= 1'b0;
            r_pulse_cnt    <= '0;
            r_pending      <= 1'b0;
            r_active       <= 1'b0;
            r_ovalid       <= 1'b0;
        end else begin
            // Drop the output beat once taken, unless a new one loads
            if (r_ovalid && i_m_axis_tready && !w_load_out) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_seq)
                S_IDLE: begin
                    if (w_accept) begin
                        r_toggle       <= n_toggle;
                        r_stage        <= n_stage;
                        r_level        <= n_level;
                        r_gate         <= n_gate;
                        r_pulse_active <= n_pulse_active;
                        r_pulse_cnt    <= n_pulse_cnt;
                        r_prev_clock   <= f_clock;
                        r_prev_arm     <= f_arm;
                        r_prev_reset   <= f_reset;
                        r_pending      <= (n_toggle == TG_ARMED) || (n_toggle == TG_DISARM);
                        r_active       <= (n_toggle == TG_GATING) || (n_toggle == TG_DISARM);
                        r_sustain      <= w_sustain;
                        r_in_left      <= f_in_left;
                        r_in_right     <= f_in_right;
                        r_left_conn    <= f_left_conn;
                        r_right_conn   <= f_right_conn;
                        r_seq          <= w_div_go ? S_DIV : S_ENV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_step <= (w_quotient == '0) ? LVW'(1) : w_quotient;
                        r_seq  <= S_ENV;
                    end
                end
                S_ENV: begin
                    r_level <= w_env_level;
                    r_stage <= w_env_stage;
                    r_seq   <= S_MULL;
                end
                S_MULL: begin
                    r_seq <= S_MULR;
                end
                S_MULR: begin
                    r_left_tmp <= w_vca_out;
                    r_seq      <= S_DONE;
                end
                S_DONE: begin
                    if (w_load_out) begin
                        r_o_left    <= r_left_tmp;
                        r_o_right   <= w_vca_out;
                        r_o_gate    <= r_gate;
                        r_o_pending <= r_pending;
                        r_o_active  <= r_active;
                        r_o_env     <= w_env16;
                        r_ovalid    <= 1'b1;
                        r_seq       <= S_IDLE;
                    end
                end
                default: begin
                    r_seq <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {5'b0, r_o_env, r_o_active, r_o_pending, r_o_gate,
                              r_o_right, r_o_left};

    // Checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_axis_tready)
        else $error("input taken while an item is in flight");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_seq == S_DIV))
        else $error("divider finished outside the divide step");

    a_level_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= FULL_LEVEL)
        else $error("envelope level above full scale");

    a_stop_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_seq == S_MULL) && (r_stage == ENV_STOP)) |-> (r_level == '0))
        else $error("stopped envelope holds a nonzero level");

    a_no_load_over_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_m_axis_tready) |-> !w_load_out)
        else $error("output beat overwritten while stalled");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ctgae_pkg::*;

    localparam int FRAC      = 8;
    localparam int STALL_MAX = 3000;
    localparam bit [24:0] FULL_LVL = 25'(16'hFFFF) << FRAC;

    // One audio sample period as it enters the block
    typedef struct {
        bit                 clk_lvl;
        bit                 arm_lvl;
        bit                 rst_lvl;
        logic signed [17:0] sustain;
        logic [19:0]        attack_len;
        logic [19:0]        release_len;
        logic signed [15:0] left;
        logic signed [15:0] right;
        bit                 left_conn;
        bit                 right_conn;
    } t_frame_in;

    // One processed sample period as it leaves the block
    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               gate;
        logic               pending;
        logic               active;
        logic [15:0]        env;
    } t_frame_out;

    // Toggle gate and envelope predictor with its queue of expected frames
    class envelope_scoreboard;
        bit         unarm_off = 1'b0;
        bit         trig_mode = 1'b0;
        bit [15:0]  pulse_len = 16'd48;
        bit [19:0]  min_len   = 20'd48;
        bit [19:0]  max_len   = 20'd480000;
        t_toggle    tog       = TG_IDLE;
        t_env_stage stage     = ENV_STOP;
        bit [24:0]  level;
        bit [23:0]  step;
        bit         prev_clk, prev_arm, prev_rst;
        bit         gate, pulse_on;
        bit [16:0]  pulse_cnt;
        t_frame_out expected_q[$];
        int         n_errors;
        int         n_beats;

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_DISABLE_UNARM: unarm_off = val[0];
                CFG_TRIGGER_MODE:  trig_mode = val[0];
                CFG_PULSE_LEN:     pulse_len = val[15:0];
                CFG_MIN_ENV_LEN:   min_len   = val;
                CFG_MAX_ENV_LEN:   max_len   = val;
                default: ;
            endcase
        endfunction

        // Clamp a length; a ramp runs only if it is long enough and not zero
        function bit ramp_len(bit [19:0] raw, output bit [19:0] eff);
            eff = (raw > max_len) ? max_len : raw;
            return (raw >= min_len) && (eff != 0);
        endfunction

        function void fire_pulse();
            gate      = 1'b1;
            pulse_on  = 1'b1;
            pulse_cnt = {1'b0, pulse_len};
        endfunction

        // Multiply by the gain and take the floor of the 16-bit shift
        function logic signed [15:0] scale(logic signed [15:0] s, bit [16:0] g);
            longint p;
            p = longint'(s) * longint'(g);
            return 16'(p >>> 16);
        endfunction

        function void note_frame(t_frame_in f);
            bit [24:0]  sus;
            bit [19:0]  eff;
            bit         clk_edge, arm_edge;
            bit [15:0]  env16;
            bit [16:0]  gain;
            t_frame_out want;

            // Saturate sustain to 0..1.0
            if (f.sustain < 0) sus = '0;
            else if (f.sustain > 65535) sus = FULL_LVL;
            else sus = 25'(f.sustain[15:0]) << FRAC;

            clk_edge = f.clk_lvl && !prev_clk;
            prev_clk = f.clk_lvl;

            // Reset edge stops the envelope, goes idle and drops the gate or fires a pulse if gating
            if (f.rst_lvl && !prev_rst) begin
                gate = 1'b0;
                if (trig_mode && tog == TG_GATING) fire_pulse();
                stage = ENV_STOP;
                level = '0;
                tog   = TG_IDLE;
            end
            prev_rst = f.rst_lvl;

            arm_edge = f.arm_lvl && !prev_arm;
            prev_arm = f.arm_lvl;

            // Advance the toggle machine
            case (tog)
                TG_IDLE: begin
                    if (arm_edge) tog = TG_ARMED;
                end
                TG_ARMED: begin
                    if (arm_edge && !unarm_off) begin
                        gate = 1'b0;
                        tog  = TG_IDLE;
                    end else if (clk_edge) begin
                        gate = 1'b1;
                        if (trig_mode) fire_pulse();
                        tog = TG_GATING;
                        if (ramp_len(f.attack_len, eff)) begin
                            stage = ENV_ATTACK;
                            step  = 24'(((level < FULL_LVL) ? FULL_LVL - level : 25'd0) / eff);
                            if (step == 0) step = 24'd1;
                        end else begin
                            stage = ENV_SUSTAIN;
                        end
                    end
                end
                TG_GATING: begin
                    if (!trig_mode) gate = 1'b1;
                    if (arm_edge) tog = TG_DISARM;
                end
                default: begin
                    if (arm_edge && !unarm_off) begin
                        tog = TG_GATING;
                    end else if (clk_edge) begin
                        if (!trig_mode) gate = 1'b0;
                        else fire_pulse();
                        tog = TG_IDLE;
                        if (ramp_len(f.release_len, eff)) begin
                            stage = ENV_RELEASE;
                            step  = 24'(level / eff);
                            if (step == 0) step = 24'd1;
                        end else begin
                            stage = ENV_STOP;
                        end
                    end
                end
            endcase

            // Advance the envelope
            case (stage)
                ENV_ATTACK: begin
                    level = level + 25'(step);
                    if (level >= sus) begin
                        level = sus;
                        stage = ENV_SUSTAIN;
                    end
                end
                ENV_SUSTAIN: level = sus;
                ENV_RELEASE: begin
                    if (25'(step) > level) begin
                        level = '0;
                        stage = ENV_STOP;
                    end else begin
                        level = level - 25'(step);
                    end
                end
                default: begin
                    level = '0;
                    stage = ENV_STOP;
                end
            endcase

            // Scale both channels; an unpatched channel stands in at full scale
            env16      = level[FRAC +: 16];
            gain       = {1'b0, env16} + 17'(env16[15]);
            want.left  = scale(f.left_conn  ? f.left  : 16'sh7FFF, gain);
            want.right = scale(f.right_conn ? f.right : 16'sh7FFF, gain);

            // Count the trigger pulse down
            if (trig_mode && pulse_on) begin
                if (pulse_cnt == 0) begin
                    pulse_on = 1'b0;
                    gate     = 1'b0;
                end else begin
                    pulse_cnt--;
                end
            end

            want.gate    = gate;
            want.pending = (tog == TG_ARMED) || (tog == TG_DISARM);
            want.active  = (tog == TG_GATING) || (tog == TG_DISARM);
            want.env     = env16;
            expected_q.push_back(want);
        endfunction

        task report_mismatch(string what, longint got, longint want);
            n_errors++;
            $display("[%0t] beat %0d: %s got %0d expected %0d",
                     $time, n_beats, what, got, want);
        endtask

        task check_frame(t_frame_out got);
            t_frame_out want;
            n_beats++;
            if (expected_q.size() == 0) begin
                report_mismatch("beat with nothing pending, envelope", got.env, 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.left !== want.left) report_mismatch("out_left", got.left, want.left);
            if (got.right !== want.right) report_mismatch("out_right", got.right, want.right);
            if (got.gate !== want.gate) report_mismatch("gate_out", got.gate, want.gate);
            if (got.pending !== want.pending)
                report_mismatch("pending_flag", got.pending, want.pending);
            if (got.active !== want.active)
                report_mismatch("active_flag", got.active, want.active);
            if (got.env !== want.env) report_mismatch("envelope", got.env, want.env);
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [IN_W-1:0]      i_s_axis_tdata;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [OUT_W-1:0]     o_m_axis_tdata;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    envelope_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_cycles;
    bit gen_clk, gen_arm, gen_rst;
    int gen_clk_run;

    clocked_toggle_gate_asr_envelope_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Pack one frame, lowest field first
    function automatic logic [IN_W-1:0] pack_frame(t_frame_in f);
        logic [IN_W-1:0] d;
        d        = '0;
        d[0]     = f.clk_lvl;
        d[1]     = f.arm_lvl;
        d[2]     = f.rst_lvl;
        d[20:3]  = f.sustain;
        d[40:21] = f.attack_len;
        d[60:41] = f.release_len;
        d[76:61] = f.left;
        d[92:77] = f.right;
        d[93]    = f.left_conn;
        d[94]    = f.right_conn;
        return d;
    endfunction

    function automatic t_frame_in mk_frame(bit c, bit a, bit r, int sus, int att, int rel,
                                           int l, int rr, bit lc, bit rc);
        t_frame_in f;
        f.clk_lvl     = c;
        f.arm_lvl     = a;
        f.rst_lvl     = r;
        f.sustain     = 18'(sus);
        f.attack_len  = 20'(att);
        f.release_len = 20'(rel);
        f.left        = 16'(l);
        f.right       = 16'(rr);
        f.left_conn   = lc;
        f.right_conn  = rc;
        return f;
    endfunction

    // Mostly short lengths so ramps finish, some long ones
    function automatic logic [19:0] rand_len();
        int pick;
        pick = $urandom_range(99);
        if (pick < 65) return 20'($urandom_range(120));
        if (pick < 85) return 20'($urandom_range(2000));
        return 20'($urandom);
    endfunction

    // Clock square wave of random half periods with sparse arm and reset pulses, some noise
    function automatic t_frame_in random_frame();
        t_frame_in f;
        int pick;
        if (gen_clk_run == 0) begin
            gen_clk     = !gen_clk;
            gen_clk_run = $urandom_range(4, 1);
        end
        gen_clk_run--;
        gen_arm = gen_arm ? ($urandom_range(99) < 40) : ($urandom_range(99) < 12);
        gen_rst = gen_rst ? ($urandom_range(99) < 40) : ($urandom_range(99) < 3);
        f.clk_lvl = gen_clk;
        f.arm_lvl = gen_arm;
        f.rst_lvl = gen_rst;
        if ($urandom_range(99) < 8) begin
            f.clk_lvl = 1'($urandom);
            f.arm_lvl = 1'($urandom);
            f.rst_lvl = 1'($urandom);
        end
        pick = $urandom_range(99);
        if (pick < 60) f.sustain = 18'($urandom_range(65535));
        else if (pick < 70) f.sustain = 18'sd65535;
        else if (pick < 75) f.sustain = 18'sd0;
        else f.sustain = 18'($urandom);
        f.attack_len  = rand_len();
        f.release_len = rand_len();
        f.left        = 16'($urandom);
        f.right       = 16'($urandom);
        f.left_conn   = ($urandom_range(99) < 80);
        f.right_conn  = ($urandom_range(99) < 80);
        return f;
    endfunction

    // Offer one beat, with random gaps before it, and hold it until taken
    task automatic send_frame(input t_frame_in f);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = pack_frame(f);
        forever begin
            @(posedge i_clk);
            if (o_s_axis_tready) break;
        end
        sb.note_frame(f);
    endtask

    // Stop sending and wait for every pending frame to come back
    task automatic drain();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        sb.note_config(idx, val);
    endtask

    task automatic configure(input bit du, input bit tm, input int pl, input int mn,
                             input int mx);
        write_reg(CFG_DISABLE_UNARM, CFG_DATA_W'(du));
        write_reg(CFG_TRIGGER_MODE, CFG_DATA_W'(tm));
        write_reg(CFG_PULSE_LEN, CFG_DATA_W'(pl));
        write_reg(CFG_MIN_ENV_LEN, CFG_DATA_W'(mn));
        write_reg(CFG_MAX_ENV_LEN, CFG_DATA_W'(mx));
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Receiver stalls at random
    always @(negedge i_clk) begin
        i_m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Check each output beat
    always @(posedge i_clk) begin : out_monitor
        t_frame_out got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.left    = o_m_axis_tdata[15:0];
            got.right   = o_m_axis_tdata[31:16];
            got.gate    = o_m_axis_tdata[32];
            got.pending = o_m_axis_tdata[33];
            got.active  = o_m_axis_tdata[34];
            got.env     = o_m_axis_tdata[50:35];
            sb.check_frame(got);
        end
    end

    // End the run when no beat moves for too long
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        if (stall_cycles >= STALL_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : main
        int ph;
        int k;
        int n_rand;

        sb              = new;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        stall_cycles    = 0;
        gen_clk_run     = 0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_DISABLE_UNARM;
        i_cfg_data      = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (ph = 0; ph < 6; ph++) begin
            drain();
            // Register settings per phase, extremes among them
            case (ph)
                0: configure(1'b0, 1'b0, 48, 48, 480000);
                1: configure(1'b1, 1'b1, 0, 0, 0);
                2: configure(1'b0, 1'b1, 65535, 4, 60);
                3: configure(1'b1, 1'b0, 1000, 1048575, 1048575);
                4: configure(1'b0, 1'b1, 3, 0, 1);
                default: configure(1'b0, 1'b0, 48, 16, 300);
            endcase
            case (ph % 3)
                0: begin
                    send_idle_pct = 32;
                    recv_idle_pct = 57;
                end
                1: begin
                    send_idle_pct = 57;
                    recv_idle_pct = 32;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            n_rand = 225;
            if (ph == 0) begin
                // Walk every toggle transition at the field extremes
                send_frame(mk_frame(0, 0, 0, 65535, 0, 0, -32768, 32767, 1, 1));
                send_frame(mk_frame(0, 1, 0, 0, 0, 0, 32767, -32768, 1, 1));
                send_frame(mk_frame(1, 0, 0, 65535, 10, 0, -32768, 32767, 1, 1));
                send_frame(mk_frame(0, 1, 0, 131071, 0, 0, 12345, -1, 1, 1));
                send_frame(mk_frame(0, 0, 0, 65535, 0, 0, -1, 1, 1, 1));
                send_frame(mk_frame(0, 1, 0, 65535, 0, 0, 100, -100, 1, 1));
                send_frame(mk_frame(0, 0, 0, 65535, 0, 0, 100, -100, 1, 1));
                send_frame(mk_frame(0, 1, 0, 65535, 0, 0, 100, -100, 1, 1));
                send_frame(mk_frame(1, 0, 0, 65535, 0, 1048575, -32768, 32767, 1, 1));
                send_frame(mk_frame(0, 1, 0, 65535, 0, 0, -32768, 32767, 1, 1));
                send_frame(mk_frame(0, 0, 0, 65535, 0, 0, -32768, 32767, 1, 1));
                send_frame(mk_frame(0, 1, 0, 65535, 0, 0, -32768, 32767, 1, 1));
                send_frame(mk_frame(0, 0, 0, 65535, 0, 0, -32768, 32767, 1, 1));
                send_frame(mk_frame(0, 1, 0, 65535, 0, 0, -32768, 32767, 1, 1));
                send_frame(mk_frame(1, 0, 0, 131071, 1048575, 0, 32767, 32767, 1, 1));
                send_frame(mk_frame(0, 0, 0, -65536, 0, 0, 32767, 32767, 1, 1));
                send_frame(mk_frame(0, 0, 1, 65535, 0, 0, 32767, 32767, 1, 1));
                send_frame(mk_frame(0, 0, 0, 65535, 0, 0, 32767, 32767, 1, 1));
                send_frame(mk_frame(1, 1, 1, 40000, 0, 0, 32767, 32767, 1, 1));
                send_frame(mk_frame(1, 0, 0, 40000, 0, 0, 32767, 32767, 1, 1));
                send_frame(mk_frame(0, 0, 0, 40000, 0, 0, 32767, 32767, 1, 1));
                send_frame(mk_frame(1, 0, 0, 40000, 100, 0, -20000, 20000, 1, 1));
                send_frame(mk_frame(0, 0, 0, 131071, 0, 0, 0, 0, 0, 0));
                send_frame(mk_frame(0, 1, 0, 40000, 0, 0, -20000, 20000, 1, 1));
                send_frame(mk_frame(1, 0, 0, 40000, 0, 0, -20000, 20000, 1, 1));
                send_frame(mk_frame(0, 0, 0, 40000, 0, 0, 0, 0, 0, 0));
                n_rand = 200;
            end
            for (k = 0; k < n_rand; k++) begin
                // Hold off once per phase until every frame is back
                if (k == 100) drain();
                send_frame(random_frame());
            end
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (sb.n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
